// ----- rtl/core/rlpis_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package rlpis_pkg;

  // Width of a reportable byte offset; the offset counter carries one more bit
  // so that a stream running past the range can be seen.
  localparam int OFFSET_BITS = 16;
  localparam int LEN_BITS    = 64;
  localparam int COUNT_BITS  = 16;
  localparam int LBYTE_BITS  = 4;

  localparam logic [COUNT_BITS-1:0] MAX_FIELDS_RESET = 16'd16;

  // Configuration register map (word index taken from paddr[2]).
  localparam logic CFG_IDX_MAX_FIELDS = 1'b0;

  // Parse phase of the current item.
  typedef enum logic [1:0] {
    PH_PREFIX  = 2'd0,
    PH_LENGTH  = 2'd1,
    PH_PAYLOAD = 2'd2
  } phase_t;

  // Record status codes.
  typedef enum logic [1:0] {
    ST_ITEM    = 2'd0,
    ST_DONE    = 2'd1,
    ST_BUFEND  = 2'd2,
    ST_TOOLONG = 2'd3
  } status_t;

  // Item kinds.
  typedef enum logic [1:0] {
    KIND_SINGLE = 2'd0,
    KIND_STRING = 2'd1,
    KIND_LIST   = 2'd2
  } kind_t;

  // One result record.
  typedef struct packed {
    status_t                 status;
    kind_t                   kind;
    logic [OFFSET_BITS-1:0]  offset;
    logic [LEN_BITS-1:0]     length;
    logic [COUNT_BITS-1:0]   count;
    logic                    last;
  } rec_t;

  // Records produced by one input beat: count and up to two records.
  typedef struct packed {
    logic [1:0] num;
    rec_t       rec0;
    rec_t       rec1;
  } push_t;

  // A terminal record carries only status, count and the last flag.
  function automatic rec_t term_rec(status_t st, logic [COUNT_BITS-1:0] cnt);
    rec_t r;
    r        = '0;
    r.status = st;
    r.kind   = KIND_SINGLE;
    r.count  = cnt;
    r.last   = 1'b1;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/rlpis_cfg_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rlpis_cfg_regs
  import rlpis_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_psel,
  input  wire logic                  cfg_penable,
  input  wire logic                  cfg_pwrite,
  input  wire logic [2:0]            cfg_paddr,
  input  wire logic [31:0]           cfg_pwdata,
  output logic      [31:0]           cfg_prdata,
  output logic                       cfg_pready,
  output logic      [COUNT_BITS-1:0] max_fields
);

  logic [COUNT_BITS-1:0] max_fields_r;
  logic                  sel_max;
  logic                  wr_en;

  assign cfg_pready = 1'b1;
  assign sel_max    = (cfg_paddr[2] == CFG_IDX_MAX_FIELDS);
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  // Register write in the access phase.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_fields_r <= MAX_FIELDS_RESET;
    end else if (wr_en && sel_max) begin
      max_fields_r <= cfg_pwdata[COUNT_BITS-1:0];
    end
  end

  // Read-back mux.
  always_comb begin
    cfg_prdata = '0;
    if (sel_max) begin
      cfg_prdata = {{(32-COUNT_BITS){1'b0}}, max_fields_r};
    end
  end

  assign max_fields = max_fields_r;

endmodule

`default_nettype wire

// ----- rtl/core/rlpis_parser.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rlpis_parser
  import rlpis_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  beat,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  end_of_stream,
  input  wire logic [COUNT_BITS-1:0] max_fields,
  output push_t                      push
);

  phase_t                 phase_r, phase_nxt;
  logic [LEN_BITS-1:0]    acc_r, acc_nxt;
  logic [LBYTE_BITS-1:0]  lbl_r, lbl_nxt;
  logic [LEN_BITS-1:0]    pleft_r, pleft_nxt;
  logic [OFFSET_BITS:0]   off_r, off_nxt;
  logic [COUNT_BITS-1:0]  found_r, found_nxt;
  kind_t                  pkind_r, pkind_nxt;
  logic [OFFSET_BITS-1:0] pstart_r, pstart_nxt;
  logic                   stopped_r, stopped_nxt;

  logic [OFFSET_BITS-1:0] pos;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [5:0]             short_len;
  logic                   complete;
  logic                   clear;
  logic                   parsed;

  assign pos       = off_r[OFFSET_BITS-1:0];
  assign pos_inc   = pos + 1'b1;
  assign short_len = data_byte[5:0];

  // One byte of the parse: next state and the records it produces.
  always_comb begin
    phase_nxt   = phase_r;
    acc_nxt     = acc_r;
    lbl_nxt     = lbl_r;
    pleft_nxt   = pleft_r;
    off_nxt     = off_r;
    found_nxt   = found_r;
    pkind_nxt   = pkind_r;
    pstart_nxt  = pstart_r;
    stopped_nxt = stopped_r;
    complete    = 1'b0;
    clear       = 1'b0;
    parsed      = 1'b0;
    push        = '0;

    if (beat) begin
      priority if (stopped_r) begin
        // Ignore bytes until the end of the buffer.
        clear = end_of_stream;
      end else if (off_r[OFFSET_BITS]) begin
        push.num  = 2'd1;
        push.rec0 = term_rec(ST_TOOLONG, found_r);
        clear       = end_of_stream;
        stopped_nxt = ~end_of_stream;
      end else if ((phase_r == PH_PREFIX) && (found_r >= max_fields)) begin
        push.num  = 2'd1;
        push.rec0 = term_rec(ST_DONE, found_r);
        clear       = end_of_stream;
        stopped_nxt = ~end_of_stream;
      end else begin
        parsed  = 1'b1;
        off_nxt = off_r + 1'b1;
      end

      if (parsed) begin
        unique case (phase_r)
          PH_PREFIX: begin
            if (!data_byte[7]) begin
              // Single byte item.
              pkind_nxt  = KIND_SINGLE;
              pstart_nxt = pos;
              acc_nxt    = '0;
              complete   = 1'b1;
            end else if (data_byte[5:3] != 3'b111) begin
              // Short string or short list.
              pkind_nxt  = data_byte[6] ? KIND_LIST : KIND_STRING;
              acc_nxt    = {{(LEN_BITS-6){1'b0}}, short_len};
              pstart_nxt = ((short_len == 6'd0) && !data_byte[6]) ? pos : pos_inc;
              if (short_len == 6'd0) begin
                complete = 1'b1;
              end else begin
                pleft_nxt = {{(LEN_BITS-6){1'b0}}, short_len};
                phase_nxt = PH_PAYLOAD;
              end
            end else begin
              // Long form: 1 to 8 length bytes follow.
              pkind_nxt = data_byte[6] ? KIND_LIST : KIND_STRING;
              lbl_nxt   = {1'b0, data_byte[2:0]} + 1'b1;
              acc_nxt   = '0;
              phase_nxt = PH_LENGTH;
            end
          end
          PH_LENGTH: begin
            acc_nxt = {acc_r[LEN_BITS-9:0], data_byte};
            lbl_nxt = lbl_r - 1'b1;
            if (lbl_nxt == '0) begin
              pstart_nxt = pos_inc;
              if (acc_nxt == '0) begin
                complete = 1'b1;
              end else begin
                pleft_nxt = acc_nxt;
                phase_nxt = PH_PAYLOAD;
              end
            end
          end
          PH_PAYLOAD: begin
            pleft_nxt = pleft_r - 1'b1;
            if (pleft_nxt == '0) begin
              complete = 1'b1;
            end
          end
          default: begin
            phase_nxt = PH_PREFIX;
          end
        endcase

        if (complete) begin
          phase_nxt        = PH_PREFIX;
          found_nxt        = found_r + 1'b1;
          push.rec0.status = ST_ITEM;
          push.rec0.kind   = pkind_nxt;
          push.rec0.offset = pstart_nxt;
          push.rec0.length = acc_nxt;
          push.rec0.count  = found_nxt;
          push.rec0.last   = 1'b0;
          push.num         = 2'd1;
          if (found_nxt >= max_fields) begin
            push.num    = 2'd2;
            push.rec1   = term_rec(ST_DONE, found_nxt);
            clear       = end_of_stream;
            stopped_nxt = ~end_of_stream;
          end else if (end_of_stream) begin
            push.num  = 2'd2;
            push.rec1 = term_rec(ST_DONE, found_nxt);
            clear     = 1'b1;
          end
        end else if (end_of_stream) begin
          push.num  = 2'd1;
          push.rec0 = term_rec(ST_BUFEND, found_r);
          clear     = 1'b1;
        end
      end

      // End of buffer returns all parse state to its reset values.
      if (clear) begin
        phase_nxt   = PH_PREFIX;
        acc_nxt     = '0;
        lbl_nxt     = '0;
        pleft_nxt   = '0;
        off_nxt     = '0;
        found_nxt   = '0;
        pkind_nxt   = KIND_SINGLE;
        pstart_nxt  = '0;
        stopped_nxt = 1'b0;
      end
    end
  end

  // Parse state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_PREFIX;
      acc_r     <= '0;
      lbl_r     <= '0;
      pleft_r   <= '0;
      off_r     <= '0;
      found_r   <= '0;
      pkind_r   <= KIND_SINGLE;
      pstart_r  <= '0;
      stopped_r <= 1'b0;
    end else begin
      phase_r   <= phase_nxt;
      acc_r     <= acc_nxt;
      lbl_r     <= lbl_nxt;
      pleft_r   <= pleft_nxt;
      off_r     <= off_nxt;
      found_r   <= found_nxt;
      pkind_r   <= pkind_nxt;
      pstart_r  <= pstart_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rlpis_out_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module rlpis_out_queue
  import rlpis_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       room,
  output logic       rec_valid,
  input  wire logic  rec_ready,
  output rec_t       rec
);

  localparam int DEPTH = 4;
  localparam int PTR_BITS = $clog2(DEPTH);

  rec_t                mem_r [DEPTH];
  logic [PTR_BITS-1:0] wr_r, wr_nxt;
  logic [PTR_BITS-1:0] rd_r, rd_nxt;
  logic [PTR_BITS:0]   cnt_r, cnt_nxt;
  logic [PTR_BITS-1:0] wr_inc;
  logic                pop;

  // Room for the two records a single beat can produce.
  assign room      = (cnt_r <= (PTR_BITS+1)'(DEPTH - 2));
  assign rec_valid = (cnt_r != '0);
  assign rec       = mem_r[rd_r];
  assign pop       = rec_valid & rec_ready;
  assign wr_inc    = wr_r + 1'b1;

  // Pointer and fill count update.
  always_comb begin
    wr_nxt  = wr_r + PTR_BITS'(push.num);
    rd_nxt  = rd_r + PTR_BITS'(pop);
    cnt_nxt = cnt_r + (PTR_BITS+1)'(push.num) - (PTR_BITS+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Record storage.
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem_r[wr_r] <= push.rec0;
    end
    if (push.num == 2'd2) begin
      mem_r[wr_inc] <= push.rec1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rlp_item_splitter.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Splits an RLP-encoded buffer into its top-level items.
// Input channel: one buffer byte per beat on in_tdata, in_tlast on the final
// byte of a buffer. Output channel: one record per beat with status and item
// kind on out_tuser, payload offset, payload length and item count on
// out_tdata, and out_tlast on the final record of a buffer.
// Configuration: one APB register, max_fields at byte address 0.
// The records for a byte are written into the output queue as it is taken.
// Throughput: one byte per cycle while in_tready is high. A byte that both
// completes an item and closes a buffer or reaches the item limit gives two
// records, which leave one by one through the four-entry output queue;
// in_tready needs two free entries, so one such byte does not stall input.
// Reset clears the parse state and the queue and sets max_fields to 16.
// When the receiver stalls, records wait in the queue and in_tready falls
// once fewer than two entries are free; nothing is dropped.
module rlp_item_splitter
  import rlpis_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] data_byte
  input  wire logic        in_tlast,
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [15:0] payload_offset, [79:16] payload_length, [95:80] field_count
  output logic [95:0]      out_tdata,
  output logic [3:0]       out_tuser,  // [1:0] status, [3:2] item_kind
  output logic             out_tlast,
  // Configuration port.
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready
);

  logic [COUNT_BITS-1:0] max_fields;
  push_t                 push;
  logic                  room;
  logic                  beat;
  rec_t                  rec;

  assign in_tready = room;
  assign beat      = in_tvalid & in_tready;

  rlpis_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .max_fields  (max_fields)
  );

  rlpis_parser u_parser (
    .clk           (clk),
    .rst_n         (rst_n),
    .beat          (beat),
    .data_byte     (in_tdata),
    .end_of_stream (in_tlast),
    .max_fields    (max_fields),
    .push          (push)
  );

  rlpis_out_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .rec_valid (out_tvalid),
    .rec_ready (out_tready),
    .rec       (rec)
  );

  // Pack the head record onto the output beat.
  assign out_tdata = {rec.count, rec.length, rec.offset};
  assign out_tuser = {rec.kind, rec.status};
  assign out_tlast = rec.last;

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;
  import rlpis_pkg::*;

  typedef logic [7:0] byte_q_t[$];

  // max_fields sits in word 0 of the register map.
  localparam logic [2:0] MAX_FIELDS_ADDR = {CFG_IDX_MAX_FIELDS, 2'b00};

  // Predicts the records of the splitter and checks what comes out against them.
  class rlp_split_board;
    rec_t        records_due[$];
    int          fails;
    logic [15:0] field_limit;
    phase_t      ph;
    logic [63:0] len_acc;
    logic [3:0]  lbytes_left;
    logic [63:0] pay_left;
    logic [16:0] next_off;
    logic [15:0] n_items;
    kind_t       pend_kind;
    logic [16:0] pend_start;
    bit          halted;

    function new();
      fails = 0;
      field_limit = MAX_FIELDS_RESET;
      restart();
    endfunction

    // Parse state of one buffer; the limit register survives.
    function void restart();
      ph = PH_PREFIX;
      len_acc = '0;
      lbytes_left = '0;
      pay_left = '0;
      next_off = '0;
      n_items = '0;
      pend_kind = KIND_SINGLE;
      pend_start = '0;
      halted = 1'b0;
    endfunction

    function void emit(status_t st, kind_t k, logic [16:0] off, logic [63:0] len,
                       logic last);
      rec_t r;
      r.status = st;
      r.kind = k;
      r.offset = off[15:0];
      r.length = len;
      r.count = n_items;
      r.last = last;
      records_due.push_back(r);
    endfunction

    function void stop_here(logic eos);
      if (eos) begin
        restart();
      end else begin
        halted = 1'b1;
      end
    endfunction

    // Works out the records caused by one accepted byte.
    function void split_byte(logic [7:0] b, logic eos);
      logic [16:0] pos;
      bit          complete;
      complete = 1'b0;
      if (halted) begin
        if (eos) restart();
        return;
      end
      // The offset counter saturates one step past the reportable range.
      if (next_off[16]) begin
        emit(ST_TOOLONG, KIND_SINGLE, '0, '0, 1'b1);
        stop_here(eos);
        return;
      end
      pos = next_off;
      next_off = next_off + 17'd1;
      case (ph)
        PH_PREFIX: begin
          if (n_items >= field_limit) begin
            emit(ST_DONE, KIND_SINGLE, '0, '0, 1'b1);
            stop_here(eos);
            return;
          end
          if (b < 8'h80) begin
            pend_kind = KIND_SINGLE;
            pend_start = pos;
            len_acc = '0;
            complete = 1'b1;
          end else if (b < 8'hb8 || (b >= 8'hc0 && b < 8'hf8)) begin
            pend_kind = (b < 8'hb8) ? KIND_STRING : KIND_LIST;
            len_acc = 64'(b - ((b < 8'hb8) ? 8'h80 : 8'hc0));
            // An empty short string points at its prefix, everything else past it.
            pend_start = (len_acc == 0 && pend_kind == KIND_STRING) ? pos : pos + 17'd1;
            if (len_acc == 0) begin
              complete = 1'b1;
            end else begin
              pay_left = len_acc;
              ph = PH_PAYLOAD;
            end
          end else begin
            pend_kind = (b < 8'hc0) ? KIND_STRING : KIND_LIST;
            lbytes_left = 4'(b - ((b < 8'hc0) ? 8'hb7 : 8'hf7));
            len_acc = '0;
            ph = PH_LENGTH;
          end
        end
        PH_LENGTH: begin
          len_acc = {len_acc[55:0], b};
          lbytes_left = lbytes_left - 4'd1;
          if (lbytes_left == 0) begin
            pend_start = pos + 17'd1;
            if (len_acc == 0) begin
              complete = 1'b1;
            end else begin
              pay_left = len_acc;
              ph = PH_PAYLOAD;
            end
          end
        end
        default: begin
          pay_left = pay_left - 64'd1;
          if (pay_left == 0) complete = 1'b1;
        end
      endcase
      if (complete) begin
        ph = PH_PREFIX;
        n_items = n_items + 16'd1;
        emit(ST_ITEM, pend_kind, pend_start, len_acc, 1'b0);
        if (n_items >= field_limit) begin
          emit(ST_DONE, KIND_SINGLE, '0, '0, 1'b1);
          stop_here(eos);
        end else if (eos) begin
          emit(ST_DONE, KIND_SINGLE, '0, '0, 1'b1);
          restart();
        end
      end else if (eos) begin
        emit(ST_BUFEND, KIND_SINGLE, '0, '0, 1'b1);
        restart();
      end
    endfunction

    task report(string msg);
      fails++;
      if (fails <= 40) $display("%0t ns mismatch: %s", $time, msg);
    endtask

    // Compares one output beat with the oldest predicted record.
    task check_record(rec_t got);
      rec_t want;
      if (records_due.size() == 0) begin
        report($sformatf("record with nothing predicted: %p", got));
        return;
      end
      want = records_due.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.kind !== want.kind)
        report($sformatf("item_kind got %0d want %0d", got.kind, want.kind));
      if (got.offset !== want.offset)
        report($sformatf("payload_offset got %0d want %0d", got.offset, want.offset));
      if (got.length !== want.length)
        report($sformatf("payload_length got %0d want %0d", got.length, want.length));
      if (got.count !== want.count)
        report($sformatf("field_count got %0d want %0d", got.count, want.count));
      if (got.last !== want.last)
        report($sformatf("last got %0b want %0b", got.last, want.last));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [95:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  rlp_split_board board;
  bit             calm;
  int             hold_cycles;

  rlp_item_splitter DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
  endfunction

  // Every accepted input beat feeds the predictor.
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) board.split_byte(in_tdata, in_tlast);
  end

  // Every accepted output beat is checked.
  always @(posedge clk) begin
    rec_t seen;
    if (rst_n && out_tvalid && out_tready) begin
      seen.status = status_t'(out_tuser[1:0]);
      seen.kind = kind_t'(out_tuser[3:2]);
      seen.offset = out_tdata[15:0];
      seen.length = out_tdata[79:16];
      seen.count = out_tdata[95:80];
      seen.last = out_tlast;
      board.check_record(seen);
    end
  end

  // Receiver: random stalls, plus a long hold-off when one is asked for.
  initial begin : rx_side
    int stall;
    stall = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles = hold_cycles - 1;
      end else if (stall > 0) begin
        out_tready <= 1'b0;
        stall--;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_tready <= 1'b0;
        stall = gap_len() - 1;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offers one byte, with an optional gap in front, and waits for the handshake.
  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    gap = (calm || $urandom_range(0, 2) != 0) ? 0 : gap_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= b;
    in_tlast <= eos;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_stream(input byte_q_t q, input bit closes);
    foreach (q[i]) send_byte(q[i], closes && (i == q.size() - 1));
  endtask

  // Stops sending until every predicted record is out, then lets the pipe empty.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (board.records_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Writes max_fields over the config port and reads it back.
  task automatic write_limit(input logic [15:0] value);
    cfg_paddr <= MAX_FIELDS_ADDR;
    cfg_pwdata <= {16'd0, value};
    cfg_pwrite <= 1'b1;
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    board.field_limit = value;
    @(negedge clk);
    cfg_pwrite <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[15:0] !== value)
      board.report($sformatf("max_fields read %0d want %0d", cfg_prdata[15:0], value));
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Appends one well-formed item with random content.
  function automatic void add_item(ref byte_q_t q);
    int pick;
    int len;
    int nb;
    pick = $urandom_range(0, 4);
    len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 55) : $urandom_range(0, 4);
    case (pick)
      0: q.push_back(8'($urandom_range(0, 127)));
      1: q.push_back(8'h80 + 8'(len));
      2: q.push_back(8'hc0 + 8'(len));
      default: begin
        // Long form: the length goes big-endian with leading zero bytes.
        nb = $urandom_range(1, 8);
        q.push_back(((pick == 3) ? 8'hb7 : 8'hf7) + 8'(nb));
        for (int i = nb - 1; i >= 0; i--) q.push_back((i == 0) ? 8'(len) : 8'h00);
      end
    endcase
    if (pick != 0) repeat (len) q.push_back(8'($urandom));
  endfunction

  // A buffer is mostly well-formed items, sometimes cut short, sometimes noise.
  function automatic byte_q_t make_stream();
    byte_q_t q;
    int      shape;
    int      cut;
    shape = $urandom_range(0, 9);
    if (shape == 0) begin
      repeat ($urandom_range(1, 12)) q.push_back(8'($urandom));
    end else begin
      repeat ($urandom_range(1, 6)) add_item(q);
      if (shape == 1 && q.size() > 1) begin
        cut = $urandom_range(1, q.size() - 1);
        while (q.size() > cut) void'(q.pop_back());
      end
    end
    return q;
  endfunction

  initial begin
    #15_000_000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    byte_q_t     q;
    logic [15:0] limits[6];
    int          budgets[6];
    int          sent;
    board = new();
    calm = 1'b0;
    hold_cycles = 0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tlast = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Every prefix range once, empty short and long forms, reset limit of 16.
    q = '{8'h00, 8'h7f, 8'h80, 8'hc0, 8'h81, 8'haa, 8'hc1, 8'h55,
          8'hb8, 8'h00, 8'hf8, 8'h01, 8'h33};
    send_stream(q, 1'b1);
    // Buffer ends while the length is still being gathered.
    q = '{8'hb9, 8'hff};
    send_stream(q, 1'b1);
    settle();

    // Limit reached on an item; the rest of the buffer is ignored.
    write_limit(16'd2);
    q = '{8'hc0, 8'h80, 8'h05, 8'h06};
    send_stream(q, 1'b1);
    settle();
    // A limit of zero stops at the first prefix.
    write_limit(16'd0);
    q = '{8'h7f};
    send_stream(q, 1'b1);
    settle();
    // Limit lowered below the item count in the middle of a buffer.
    write_limit(16'd16);
    q = '{8'h01, 8'h02};
    send_stream(q, 1'b0);
    settle();
    write_limit(16'd1);
    q = '{8'h03, 8'h04};
    send_stream(q, 1'b1);
    settle();

    // Random buffers under several limits.
    limits = '{16'd16, 16'hffff, 16'd3, 16'd1, 16'd0, 16'd0};
    limits[5] = 16'($urandom_range(2, 40));
    budgets = '{400, 400, 300, 250, 40, 300};
    for (int ph_i = 0; ph_i < 6; ph_i++) begin
      write_limit(limits[ph_i]);
      if (ph_i == 1) begin
        // The receiver holds off while single bytes keep coming, so the
        // output queue fills and the input stalls.
        calm = 1'b1;
        hold_cycles = 300;
        q = {};
        repeat (40) q.push_back(8'($urandom_range(0, 127)));
        send_stream(q, 1'b1);
        settle();
      end
      sent = 0;
      while (sent < budgets[ph_i]) begin
        calm = ($urandom_range(0, 4) == 0);
        q = make_stream();
        send_stream(q, 1'b1);
        sent += q.size();
      end
      settle();
    end
    calm = 1'b0;

    settle();
    repeat (10) @(posedge clk);
    if (board.fails == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
